/* sv/aps_pkg.sv */
package aps_pkg;

    localparam int PRIO_BITS = 6;

    typedef logic signed [PRIO_BITS-1:0] prio_t;

    localparam prio_t PRIO_MIN  = -6'sd20;
    localparam prio_t PRIO_MAX  = 6'sd20;
    // Starts above every legal priority so the first entry always wins.
    localparam prio_t BEST_INIT = 6'sd21;

    typedef enum logic [1:0] {
        REQ_APPEND,
        REQ_REMOVE,
        REQ_SET,
        REQ_SCHED
    } aps_req_t;

    typedef enum logic [2:0] {
        STAT_OK,
        STAT_EMPTY,
        STAT_FULL,
        STAT_NOT_FOUND,
        STAT_BAD_PRIO,
        STAT_DUPLICATE
    } aps_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } aps_state_t;

    typedef struct packed {
        logic        capture;
        logic        issue;
        logic        scan_mode;
        logic        shift_mode;
        logic        shift_start;
        logic        commit_append;
        logic        commit_set;
        logic        commit_sched;
        logic        count_dec;
        logic        set_result;
        aps_status_t res_code;
        logic        res_picked;
        logic        load_out;
    } aps_cmd_t;

    typedef struct packed {
        aps_req_t req_type;
        logic     bp_bad;
        logic     ap_bad;
        logic     found;
        logic     full;
        logic     empty;
        logic     issue_done;
        logic     chk_vld;
    } aps_stat_t;

    function automatic logic prio_ok(prio_t p);
        return (p >= PRIO_MIN) && (p <= PRIO_MAX);
    endfunction

endpackage

/* sv/aps_req_if.sv */
interface aps_req_if #(
    parameter int ID_BITS = 8
);
    logic                                valid;
    logic                                ready;
    logic [1:0]                          req_type;
    logic [ID_BITS-1:0]                  task_ident;
    logic signed [aps_pkg::PRIO_BITS-1:0] base_prio;
    logic signed [aps_pkg::PRIO_BITS-1:0] aged_prio;

    modport source (
        output valid, req_type, task_ident, base_prio, aged_prio,
        input  ready
    );

    modport sink (
        input  valid, req_type, task_ident, base_prio, aged_prio,
        output ready
    );
endinterface

/* sv/aps_rsp_if.sv */
interface aps_rsp_if #(
    parameter int ID_BITS  = 8,
    parameter int CNT_BITS = 5
);
    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic [ID_BITS-1:0]  picked_ident;
    logic                picked_valid;
    logic [CNT_BITS-1:0] entry_count;

    modport source (
        output valid, status, picked_ident, picked_valid, entry_count,
        input  ready
    );

    modport sink (
        input  valid, status, picked_ident, picked_valid, entry_count,
        output ready
    );
endinterface

/* sv/aps_ram.sv */
module aps_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/aps_datapath.sv */
module aps_datapath #(
    parameter int MAX_TASKS = 16,
    parameter int ID_BITS   = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  aps_pkg::aps_cmd_t                     cmd,
    output aps_pkg::aps_stat_t                    stat,
    input  logic [1:0]                            req_type,
    input  logic [ID_BITS-1:0]                    task_ident,
    input  logic signed [aps_pkg::PRIO_BITS-1:0]  base_prio,
    input  logic signed [aps_pkg::PRIO_BITS-1:0]  aged_prio,
    output logic [2:0]                            status,
    output logic [ID_BITS-1:0]                    picked_ident,
    output logic                                  picked_valid,
    output logic [$clog2(MAX_TASKS+1)-1:0]        entry_count
);
    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int PB = aps_pkg::PRIO_BITS;
    localparam int EW = ID_BITS + 2 * PB;

    // Captured request.
    aps_pkg::aps_req_t  req_type_reg;
    logic [ID_BITS-1:0] req_id_reg;
    aps_pkg::prio_t     req_bp_reg;
    aps_pkg::prio_t     req_ap_reg;

    // Table bookkeeping and scan pipeline.
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      issue_idx_reg;
    logic [CW-1:0]      chk_idx_reg;
    logic               chk_vld_reg;
    logic               found_reg;
    logic [AW-1:0]      pos_reg;
    aps_pkg::prio_t     best_reg;
    logic [AW-1:0]      sel_reg;
    logic [ID_BITS-1:0] sel_ident_reg;
    aps_pkg::prio_t     sel_static_reg;

    // Result of the request and the output register.
    aps_pkg::aps_status_t res_status_reg;
    logic                 res_picked_reg;
    aps_pkg::aps_status_t out_status_reg;
    logic [ID_BITS-1:0]   out_ident_reg;
    logic                 out_pvalid_reg;
    logic [CW-1:0]        out_count_reg;

    // RAM port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    logic [ID_BITS-1:0] rd_ident;
    aps_pkg::prio_t     rd_static;
    aps_pkg::prio_t     rd_dyn;
    aps_pkg::prio_t     rd_aged;
    logic [CW-1:0]      shift_dst;
    logic               scan_hit;
    logic               is_sched;

    aps_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_ident  = ram_rdata[EW-1 -: ID_BITS];
    assign rd_static = aps_pkg::prio_t'(ram_rdata[2*PB-1 -: PB]);
    assign rd_dyn    = aps_pkg::prio_t'(ram_rdata[PB-1:0]);
    assign rd_aged   = (rd_dyn > aps_pkg::PRIO_MIN) ? rd_dyn - 6'sd1 : rd_dyn;
    assign shift_dst = chk_idx_reg - CW'(1);
    assign scan_hit  = cmd.scan_mode && chk_vld_reg;
    assign is_sched  = (req_type_reg == aps_pkg::REQ_SCHED);

    // The controller never overlaps a commit with a pending read, so these
    // writers are mutually exclusive.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (scan_hit && is_sched)
        begin
            ram_we    = 1'b1;
            ram_waddr = chk_idx_reg[AW-1:0];
            ram_wdata = {rd_ident, rd_static, rd_aged};
        end
        else if (cmd.shift_mode && chk_vld_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = shift_dst[AW-1:0];
            ram_wdata = ram_rdata;
        end
        else if (cmd.commit_append)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[AW-1:0];
            ram_wdata = {req_id_reg, req_bp_reg, req_ap_reg};
        end
        else if (cmd.commit_set)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg;
            ram_wdata = {req_id_reg, req_bp_reg, req_bp_reg};
        end
        else if (cmd.commit_sched)
        begin
            ram_we    = 1'b1;
            ram_waddr = sel_reg;
            ram_wdata = {sel_ident_reg, sel_static_reg, sel_static_reg};
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.commit_append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            issue_idx_reg <= '0;
            chk_idx_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            pos_reg       <= '0;
            best_reg      <= aps_pkg::BEST_INIT;
            sel_reg       <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            chk_vld_reg <= cmd.issue;
            if (cmd.issue)
            begin
                chk_idx_reg   <= issue_idx_reg;
                issue_idx_reg <= issue_idx_reg + CW'(1);
            end
            if (cmd.capture)
            begin
                issue_idx_reg <= '0;
                found_reg     <= 1'b0;
                best_reg      <= aps_pkg::BEST_INIT;
            end
            if (cmd.shift_start)
            begin
                issue_idx_reg <= CW'(pos_reg) + CW'(1);
            end
            if (scan_hit)
            begin
                if (rd_ident == req_id_reg && !found_reg)
                begin
                    found_reg <= 1'b1;
                    pos_reg   <= chk_idx_reg[AW-1:0];
                end
                if (is_sched && rd_dyn < best_reg)
                begin
                    best_reg <= rd_dyn;
                    sel_reg  <= chk_idx_reg[AW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= aps_pkg::aps_req_t'(req_type);
            req_id_reg   <= task_ident;
            req_bp_reg   <= base_prio;
            req_ap_reg   <= aged_prio;
        end
        if (scan_hit && is_sched && rd_dyn < best_reg)
        begin
            sel_ident_reg  <= rd_ident;
            sel_static_reg <= rd_static;
        end
        if (cmd.set_result)
        begin
            res_status_reg <= cmd.res_code;
            res_picked_reg <= cmd.res_picked;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_ident_reg  <= res_picked_reg ? sel_ident_reg : '0;
            out_pvalid_reg <= res_picked_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign stat.req_type   = req_type_reg;
    assign stat.bp_bad     = !aps_pkg::prio_ok(req_bp_reg);
    assign stat.ap_bad     = !aps_pkg::prio_ok(req_ap_reg);
    assign stat.found      = found_reg;
    assign stat.full       = (count_reg == CW'(MAX_TASKS));
    assign stat.empty      = (count_reg == '0);
    assign stat.issue_done = (issue_idx_reg == count_reg);
    assign stat.chk_vld    = chk_vld_reg;

    assign status       = out_status_reg;
    assign picked_ident = out_ident_reg;
    assign picked_valid = out_pvalid_reg;
    assign entry_count  = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TASKS))
        else $error("ready count exceeds table depth");

    a_commit_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit_append || cmd.commit_set || cmd.commit_sched) |-> !chk_vld_reg)
        else $error("commit write collides with a pending table read");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_append |=> count_reg == $past(count_reg) + CW'(1))
        else $error("append did not grow the table by one");

    a_shift_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_start |-> found_reg && !stat.empty)
        else $error("remove shift started without a matching entry");

    a_pick_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> !out_pvalid_reg || out_status_reg == aps_pkg::STAT_OK)
        else $error("picked task reported with an error status");
endmodule

/* sv/aps_ctrl.sv */
module aps_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  aps_pkg::aps_stat_t stat,
    output aps_pkg::aps_cmd_t  cmd
);
    aps_pkg::aps_state_t state_reg;
    aps_pkg::aps_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aps_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            aps_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = aps_pkg::S_SCAN;
                end
            end
            aps_pkg::S_SCAN:
            begin
                cmd.scan_mode = 1'b1;
                cmd.issue     = !stat.issue_done;
                if (stat.issue_done && !stat.chk_vld)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_code   = aps_pkg::STAT_OK;
                    state_next     = aps_pkg::S_DONE;
                    case (stat.req_type)
                        aps_pkg::REQ_APPEND:
                        begin
                            if (stat.bp_bad || stat.ap_bad)
                            begin
                                cmd.res_code = aps_pkg::STAT_BAD_PRIO;
                            end
                            else if (stat.found)
                            begin
                                cmd.res_code = aps_pkg::STAT_DUPLICATE;
                            end
                            else if (stat.full)
                            begin
                                cmd.res_code = aps_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cmd.commit_append = 1'b1;
                            end
                        end
                        aps_pkg::REQ_REMOVE:
                        begin
                            if (!stat.found)
                            begin
                                cmd.res_code = aps_pkg::STAT_NOT_FOUND;
                            end
                            else
                            begin
                                cmd.shift_start = 1'b1;
                                state_next      = aps_pkg::S_SHIFT;
                            end
                        end
                        aps_pkg::REQ_SET:
                        begin
                            if (stat.bp_bad)
                            begin
                                cmd.res_code = aps_pkg::STAT_BAD_PRIO;
                            end
                            else if (!stat.found)
                            begin
                                cmd.res_code = aps_pkg::STAT_NOT_FOUND;
                            end
                            else
                            begin
                                cmd.commit_set = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (stat.empty)
                            begin
                                cmd.res_code = aps_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.commit_sched = 1'b1;
                                cmd.res_picked   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            aps_pkg::S_SHIFT:
            begin
                cmd.shift_mode = 1'b1;
                cmd.issue      = !stat.issue_done;
                if (stat.issue_done && !stat.chk_vld)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = aps_pkg::S_DONE;
                end
            end
            aps_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = aps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = aps_pkg::S_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || cmd.load_out;
    end

    assign out_valid = out_valid_reg;
endmodule

/* sv/aging_priority_scheduler_top.sv */
// Ready-table scheduler with priority aging.
// Requests arrive on the req channel (append, remove, set priority, schedule) and
// every request produces exactly one result transfer on the rsp channel carrying
// a status code, the picked task id and valid flag, and the table's entry count.
// A request is taken only while the block is idle; one request is in work at a
// time. Every request first scans the n live entries from the table RAM, one read
// per cycle with a registered read; a successful remove then copies the entries
// behind the hit down by one. The result is then loaded into the output register,
// and only after that does the block return to idle for the next request. The
// scan loop through the single-read table RAM bounds the request rate.
// The result sits in an output register, so a new request is accepted while the
// previous result waits; if the receiver still stalls when the next result is
// ready, the block holds it and waits before taking more requests.
// Reset empties the table (entry count zero) and clears the output valid; table
// contents are not cleared, since entries past the count are never read.
module aging_priority_scheduler_top #(
    parameter int MAX_TASKS = 16,
    parameter int ID_BITS   = 8
) (
    input logic        clk,
    input logic        rst_n,
    aps_req_if.sink    req,
    aps_rsp_if.source  rsp
);
    aps_pkg::aps_cmd_t  cmd;
    aps_pkg::aps_stat_t stat;

    // The sequencer owns the handshakes and the request flow.
    aps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the table RAM, the scan pipeline and the result
    // registers; it only acts on commands from the sequencer.
    aps_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .ID_BITS   (ID_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req.req_type),
        .task_ident   (req.task_ident),
        .base_prio    (req.base_prio),
        .aged_prio    (req.aged_prio),
        .status       (rsp.status),
        .picked_ident (rsp.picked_ident),
        .picked_valid (rsp.picked_valid),
        .entry_count  (rsp.entry_count)
    );
endmodule
